@@ design/lrle_pkg.sv @@
// ----------------------------------------------------------------------------
// lrle_pkg: shared types and constants for the run-length pattern decoder
// Character codes, grid limits, register indexes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package lrle_pkg;

    // Width of grid dimensions, positions and run lengths.
    localparam int GW = 11;

    // Largest usable grid dimension; larger register values act as this.
    localparam logic [GW-1:0] GRID_LIMIT = 11'd1024;

    // Pattern characters.
    localparam logic [7:0] CHAR_0    = 8'h30;
    localparam logic [7:0] CHAR_9    = 8'h39;
    localparam logic [7:0] CHAR_DEAD = 8'h62;  // 'b'
    localparam logic [7:0] CHAR_LIVE = 8'h6F;  // 'o'
    localparam logic [7:0] CHAR_EOL  = 8'h24;  // '$'
    localparam logic [7:0] CHAR_END  = 8'h21;  // '!'

    // Register indexes, taken from address bit 2.
    localparam logic REG_ROW_WIDTH = 1'b0;
    localparam logic REG_ROW_COUNT = 1'b1;

    // One result beat.
    typedef struct packed {
        logic [9:0]    row_index;
        logic [9:0]    start_column;
        logic [GW-1:0] run_length;
        logic [GW-1:0] row_span;
        logic          cell_alive;
        logic          clipped;
        logic          pattern_end;
        logic          last_of_item;
    } t_result;

endpackage

`default_nettype wire

@@ design/life_rle_pattern_decoder.sv @@
// A character accepted into the input register moves into the result buffer once
// that buffer is free. Throughput: one character per cycle while the receiver is
// ready; a character with two results holds the next one back until its second beat is taken.
// Reset (synchronous, active low) clears the decoder state, empties both stages
// and sets both grid registers to 1024.
// ----------------------------------------------------------------------------
// life_rle_pattern_decoder: run-length cellular-automaton pattern body decoder
// Turns a stream of pattern characters into cell runs on a configurable grid,
// with one input register, one pass of decode logic and a two-entry result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module life_rle_pattern_decoder
    import lrle_pkg::*;
#(
    parameter int MAX_DIM = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Character input
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_char_code,
    // Result output
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [9:0]       o_row_index,
    output logic [9:0]       o_start_column,
    output logic [10:0]      o_run_length,
    output logic [10:0]      o_row_span,
    output logic             o_cell_alive,
    output logic             o_clipped,
    output logic             o_pattern_end,
    output logic             o_last_of_item
);

    // Repeat count width and the width used for position arithmetic.
    localparam int CW = $clog2(MAX_DIM + 1);
    localparam int AW = ((CW > GW) ? CW : GW) + 1;
    localparam int MW = CW + 4;

    // Configuration registers.
    logic [GW-1:0] r_row_width;
    logic [GW-1:0] r_row_count;

    // Decoder state.
    logic [CW-1:0] r_rc, n_rc;
    logic [GW-1:0] r_row, n_row;
    logic [GW-1:0] r_col, n_col;
    logic          r_fin, n_fin;

    // Input register.
    logic          r_in_valid;
    logic [7:0]    r_in_char;

    // Result buffer.
    t_result       r_res [2];
    logic [1:0]    r_cnt;

    // Handshake terms.
    logic          pop;
    logic          buf_free;
    logic          adv;
    logic          cfg_wr;

    // Decode terms.
    logic [GW-1:0] w_eff, h_eff;
    logic [CW-1:0] n_cnt;
    logic [AW-1:0] w_a, h_a, row_a, col_a, n_a;
    logic [AW-1:0] room, len, extra, first, avail, span, next_row;
    logic [MW-1:0] acc;
    logic [7:0]    digit;
    logic          is_digit;
    logic          has_a, has_b, is_end;
    t_result       res_a, res_b, slot0, slot1;
    logic [1:0]    k;

    // Configuration writes and reads.
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb begin
        prdata = '0;
        case (paddr[2])
            REG_ROW_WIDTH: prdata = {{(32-GW){1'b0}}, r_row_width};
            REG_ROW_COUNT: prdata = {{(32-GW){1'b0}}, r_row_count};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= GRID_LIMIT;
            r_row_count <= GRID_LIMIT;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_ROW_WIDTH: r_row_width <= pwdata[GW-1:0];
                REG_ROW_COUNT: r_row_count <= pwdata[GW-1:0];
                default: ;
            endcase
        end
    end

    // Stage handshake: the input stage moves on when the buffer is empty or its last beat leaves this cycle.
    assign o_valid  = (r_cnt != 2'd0);
    assign pop      = o_valid & i_ready;
    assign buf_free = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop);
    assign adv      = r_in_valid & buf_free;
    assign o_ready  = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_char <= i_char_code;
        end
    end

    // Effective grid size and operands at a common width.
    assign w_eff    = (r_row_width > GRID_LIMIT) ? GRID_LIMIT : r_row_width;
    assign h_eff    = (r_row_count > GRID_LIMIT) ? GRID_LIMIT : r_row_count;
    assign n_cnt    = (r_rc == '0) ? CW'(1) : r_rc;
    assign w_a      = AW'(w_eff);
    assign h_a      = AW'(h_eff);
    assign row_a    = AW'(r_row);
    assign col_a    = AW'(r_col);
    assign n_a      = AW'(n_cnt);
    assign room     = w_a - col_a;
    assign len      = (n_a > room) ? room : n_a;
    assign extra    = n_a - AW'(1);
    assign first    = row_a + AW'(1);
    assign avail    = h_a - first;
    assign span     = (extra > avail) ? avail : extra;
    assign next_row = row_a + n_a;
    assign digit    = r_in_char - CHAR_0;
    assign acc      = MW'(r_rc) * MW'(10) + MW'(digit[3:0]);
    assign is_digit = r_in_char inside {[CHAR_0:CHAR_9]};

    // Decode one character: next state and up to two results.
    always_comb begin
        n_rc   = r_rc;
        n_row  = r_row;
        n_col  = r_col;
        n_fin  = r_fin;
        has_a  = 1'b0;
        has_b  = 1'b0;
        is_end = 1'b0;
        res_a  = '0;
        res_b  = '0;
        res_a.row_span = GW'(1);
        res_b.row_span = GW'(1);
        if (!r_fin) begin
            if (is_digit) begin
                n_rc = (acc > MW'(MAX_DIM)) ? CW'(MAX_DIM) : acc[CW-1:0];
            end else begin
                case (r_in_char)
                    CHAR_DEAD, CHAR_LIVE: begin
                        n_rc  = '0;
                        has_a = 1'b1;
                        if (r_row >= h_eff) begin
                            res_a.clipped = 1'b1;
                        end else if (r_col >= w_eff) begin
                            res_a.row_index  = r_row[9:0];
                            res_a.cell_alive = (r_in_char == CHAR_LIVE);
                            res_a.clipped    = 1'b1;
                        end else begin
                            res_a.row_index    = r_row[9:0];
                            res_a.start_column = r_col[9:0];
                            res_a.run_length   = len[GW-1:0];
                            res_a.cell_alive   = (r_in_char == CHAR_LIVE);
                            res_a.clipped      = (n_a > room);
                            n_col = r_col + len[GW-1:0];
                        end
                    end
                    CHAR_EOL: begin
                        n_rc = '0;
                        if (r_row >= h_eff) begin
                            has_a         = 1'b1;
                            res_a.clipped = 1'b1;
                            n_row         = h_eff;
                        end else begin
                            // Pad the rest of the current row.
                            if (r_col < w_eff) begin
                                has_a              = 1'b1;
                                res_a.row_index    = r_row[9:0];
                                res_a.start_column = r_col[9:0];
                                res_a.run_length   = w_eff - r_col;
                            end
                            // Extra blank rows from the count.
                            if (extra != '0) begin
                                has_b = 1'b1;
                                if (first < h_a) begin
                                    res_b.row_index  = first[9:0];
                                    res_b.run_length = w_eff;
                                    res_b.row_span   = span[GW-1:0];
                                    res_b.clipped    = (extra > avail);
                                end else begin
                                    res_b.clipped = 1'b1;
                                end
                            end
                            n_row = (next_row > h_a) ? h_eff : next_row[GW-1:0];
                            n_col = '0;
                        end
                    end
                    CHAR_END: begin
                        n_rc   = '0;
                        is_end = 1'b1;
                        if (r_row < h_eff) begin
                            if (r_col < w_eff) begin
                                has_a              = 1'b1;
                                res_a.row_index    = r_row[9:0];
                                res_a.start_column = r_col[9:0];
                                res_a.run_length   = w_eff - r_col;
                            end
                            if (first < h_a) begin
                                has_b            = 1'b1;
                                res_b.row_index  = first[9:0];
                                res_b.run_length = w_eff;
                                res_b.row_span   = GW'(h_a - first);
                            end
                        end
                        // The end marker always gives at least one beat.
                        if (!has_a && !has_b) begin
                            has_a = 1'b1;
                        end
                        n_fin = 1'b1;
                        n_row = h_eff;
                        n_col = '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Pack the results in order and mark the final one.
    always_comb begin
        slot0 = has_a ? res_a : res_b;
        slot1 = res_b;
        k     = {1'b0, has_a} + {1'b0, has_b};
        if (k == 2'd2) begin
            slot1.last_of_item = 1'b1;
            slot1.pattern_end  = is_end;
        end else begin
            slot0.last_of_item = 1'b1;
            slot0.pattern_end  = is_end;
        end
    end

    // Decoder state advances when a character leaves the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rc  <= '0;
            r_row <= '0;
            r_col <= '0;
            r_fin <= 1'b0;
        end else if (adv) begin
            r_rc  <= n_rc;
            r_row <= n_row;
            r_col <= n_col;
            r_fin <= n_fin;
        end
    end

    // Result buffer fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (adv) begin
            r_cnt <= k;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // Result buffer payload: load both slots, or shift the second beat forward.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res[0] <= slot0;
            r_res[1] <= slot1;
        end else if (pop) begin
            r_res[0] <= r_res[1];
        end
    end

    assign o_row_index    = r_res[0].row_index;
    assign o_start_column = r_res[0].start_column;
    assign o_run_length   = r_res[0].run_length;
    assign o_row_span     = r_res[0].row_span;
    assign o_cell_alive   = r_res[0].cell_alive;
    assign o_clipped      = r_res[0].clipped;
    assign o_pattern_end  = r_res[0].pattern_end;
    assign o_last_of_item = r_res[0].last_of_item;

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for life_rle_pattern_decoder
// Feeds pattern characters through a valid/ready driver and checks every
// result beat against a decoder model kept in step with the configuration.
// A directed opening covers clipping, saturation and the grid edges. Random
// phases then run on several grid sizes under changing back-pressure, and
// one end character closes the pattern.
// ----------------------------------------------------------------------------

module testbench;
    import lrle_pkg::*;

    localparam int DIM_CAP     = 1024;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 8;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 96;

    // Clock, reset and all block inputs start at known values.
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = 3'd0;
    logic [31:0] pwdata      = 32'd0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_char_code = 8'd0;
    logic        i_ready     = 1'b0;

    logic [31:0] prdata;
    logic        pready;
    logic        o_ready;
    logic        o_valid;
    logic [9:0]  o_row_index;
    logic [9:0]  o_start_column;
    logic [10:0] o_run_length;
    logic [10:0] o_row_span;
    logic        o_cell_alive;
    logic        o_clipped;
    logic        o_pattern_end;
    logic        o_last_of_item;

    // Characters waiting to be driven and run beats waiting to be seen.
    logic [7:0]  char_backlog [$];
    t_result     expected_runs [$];

    // Decoder model state and its copy of the grid registers.
    logic [10:0] cfg_width = 11'd1024;
    logic [10:0] cfg_rows  = 11'd1024;
    int unsigned pend_count = 0;
    int unsigned row_pos    = 0;
    int unsigned col_pos    = 0;
    bit          ended      = 1'b0;

    int unsigned send_gap_pct   = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatch_count = 0;
    int unsigned stall_cycles   = 0;
    logic        in_taken       = 1'b0;

    life_rle_pattern_decoder #(
        .MAX_DIM(DIM_CAP)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_char_code    (i_char_code),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_row_index    (o_row_index),
        .o_start_column (o_start_column),
        .o_run_length   (o_run_length),
        .o_row_span     (o_row_span),
        .o_cell_alive   (o_cell_alive),
        .o_clipped      (o_clipped),
        .o_pattern_end  (o_pattern_end),
        .o_last_of_item (o_last_of_item)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_result make_run(input int unsigned row, input int unsigned col,
                                         input int unsigned len, input int unsigned span,
                                         input bit alive, input bit clip);
        t_result r;
        r.row_index    = 10'(row);
        r.start_column = 10'(col);
        r.run_length   = 11'(len);
        r.row_span     = 11'(span);
        r.cell_alive   = alive;
        r.clipped      = clip;
        r.pattern_end  = 1'b0;
        r.last_of_item = 1'b0;
        return r;
    endfunction

    // Decode one accepted character and queue the run beats it should give.
    task automatic decode_char(input logic [7:0] ch);
        t_result     runs [$];
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned room;
        int unsigned len;
        int unsigned extra;
        int unsigned first;
        int unsigned avail;
        int unsigned nxt;
        w = 32'((cfg_width > GRID_LIMIT) ? GRID_LIMIT : cfg_width);
        h = 32'((cfg_rows > GRID_LIMIT) ? GRID_LIMIT : cfg_rows);
        n = (pend_count == 0) ? 1 : pend_count;
        if (ended)
            return;
        // Digits build the repeat count, saturating at the largest dimension.
        if (ch >= CHAR_0 && ch <= CHAR_9) begin
            pend_count = pend_count * 10 + 32'(ch - CHAR_0);
            if (pend_count > DIM_CAP)
                pend_count = DIM_CAP;
            return;
        end
        case (ch)
            CHAR_DEAD, CHAR_LIVE: begin
                pend_count = 0;
                if (row_pos >= h) begin
                    runs = {runs, make_run(0, 0, 0, 1, 1'b0, 1'b1)};
                end else if (col_pos >= w) begin
                    runs = {runs, make_run(row_pos, 0, 0, 1, ch == CHAR_LIVE, 1'b1)};
                end else begin
                    room = w - col_pos;
                    len  = (n > room) ? room : n;
                    runs = {runs, make_run(row_pos, col_pos, len, 1, ch == CHAR_LIVE,
                                           n > room)};
                    col_pos += len;
                end
            end
            CHAR_EOL: begin
                pend_count = 0;
                if (row_pos >= h) begin
                    runs = {runs, make_run(0, 0, 0, 1, 1'b0, 1'b1)};
                end else begin
                    // Pad the current row, then cover the extra blank rows that exist.
                    extra = n - 1;
                    if (col_pos < w)
                        runs = {runs, make_run(row_pos, col_pos, w - col_pos, 1, 1'b0,
                                               1'b0)};
                    if (extra > 0) begin
                        first = row_pos + 1;
                        if (first < h) begin
                            avail = h - first;
                            runs = {runs, make_run(first, 0, w,
                                                   (extra > avail) ? avail : extra,
                                                   1'b0, extra > avail)};
                        end else begin
                            runs = {runs, make_run(0, 0, 0, 1, 1'b0, 1'b1)};
                        end
                    end
                    nxt     = row_pos + n;
                    row_pos = (nxt > h) ? h : nxt;
                    col_pos = 0;
                end
                if (row_pos > h)
                    row_pos = h;
            end
            CHAR_END: begin
                pend_count = 0;
                if (row_pos < h) begin
                    first = row_pos + 1;
                    if (col_pos < w)
                        runs = {runs, make_run(row_pos, col_pos, w - col_pos, 1, 1'b0,
                                               1'b0)};
                    if (first < h)
                        runs = {runs, make_run(first, 0, w, h - first, 1'b0, 1'b0)};
                end
                if (runs.size() == 0)
                    runs = {runs, make_run(0, 0, 0, 1, 1'b0, 1'b0)};
                runs[runs.size() - 1].pattern_end = 1'b1;
                ended   = 1'b1;
                row_pos = h;
                col_pos = 0;
            end
            default: begin
                return;
            end
        endcase
        if (runs.size() != 0)
            runs[runs.size() - 1].last_of_item = 1'b1;
        expected_runs = {expected_runs, runs};
    endtask

    task automatic report_field(input string field, input logic [10:0] want,
                                input logic [10:0] seen);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
        mismatch_count++;
    endtask

    // Character driver: valid holds until the beat is taken, gaps are random.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (char_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                i_valid     <= 1'b1;
                i_char_code <= char_backlog.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result receiver back-pressure.
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: check result beats, model accepted characters, watch for a hang.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            in_taken     <= 1'b0;
            stall_cycles <= 0;
        end else begin
            in_taken <= i_valid && o_ready;
            if (o_valid && i_ready) begin
                if (expected_runs.size() == 0) begin
                    $display("%0t: result beat with none expected, actual row %0d column %0d",
                             $time, o_row_index, o_start_column);
                    mismatch_count++;
                end else begin
                    want = expected_runs.pop_front();
                    if (want.row_index !== o_row_index)
                        report_field("row_index", 11'(want.row_index), 11'(o_row_index));
                    if (want.start_column !== o_start_column)
                        report_field("start_column", 11'(want.start_column),
                                     11'(o_start_column));
                    if (want.run_length !== o_run_length)
                        report_field("run_length", want.run_length, o_run_length);
                    if (want.row_span !== o_row_span)
                        report_field("row_span", want.row_span, o_row_span);
                    if (want.cell_alive !== o_cell_alive)
                        report_field("cell_alive", 11'(want.cell_alive), 11'(o_cell_alive));
                    if (want.clipped !== o_clipped)
                        report_field("clipped", 11'(want.clipped), 11'(o_clipped));
                    if (want.pattern_end !== o_pattern_end)
                        report_field("pattern_end", 11'(want.pattern_end),
                                     11'(o_pattern_end));
                    if (want.last_of_item !== o_last_of_item)
                        report_field("last_of_item", 11'(want.last_of_item),
                                     11'(o_last_of_item));
                end
            end
            if (i_valid && o_ready)
                decode_char(i_char_code);
            if ((o_valid && i_ready) || (i_valid && o_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
                $display("testbench failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            char_backlog = {char_backlog, s[i]};
    endtask

    // Wait until every character is taken and every run beat seen, then let
    // the pipeline settle in case the last characters gave no result.
    task automatic wait_drained();
        while (char_backlog.size() != 0 || i_valid || expected_runs.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic reg_write(input logic idx, input logic [10:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom & 32'hFFFF_F800) | 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_ROW_WIDTH)
            cfg_width = value;
        else
            cfg_rows = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random pattern text: mostly count-plus-tag runs, some stray bytes and
    // dangling counts. The end character is held back for the final phase.
    task automatic gen_pattern(input int unsigned target);
        int unsigned done;
        int unsigned pick;
        int unsigned n;
        int unsigned wlim;
        logic [7:0]  tag;
        logic [7:0]  junk;
        string       digits;
        done = 0;
        wlim = 32'((cfg_width > GRID_LIMIT) ? GRID_LIMIT : cfg_width);
        while (done < target) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                junk = 8'($urandom_range(255));
                if (junk == CHAR_END)
                    junk = 8'h7B;
                char_backlog = {char_backlog, junk};
                if ((junk >= CHAR_0 && junk <= CHAR_9) || junk == CHAR_DEAD ||
                    junk == CHAR_LIVE || junk == CHAR_EOL)
                    done++;
            end else if (pick < 13) begin
                digits = $sformatf("%0d", $urandom_range(30));
                push_text(digits);
                done += digits.len();
            end else begin
                pick = $urandom_range(99);
                tag  = (pick < 45) ? CHAR_DEAD : (pick < 85) ? CHAR_LIVE : CHAR_EOL;
                pick = $urandom_range(99);
                // Row ends mostly advance one row so the grid lasts the run.
                if (tag == CHAR_EOL)
                    n = (pick < 70) ? 0 : (pick < 92) ? $urandom_range(3, 1)
                                                      : $urandom_range(24, 4);
                else
                    n = (pick < 25) ? 0 :
                        (pick < 55) ? $urandom_range(9, 1) :
                        (pick < 80) ? $urandom_range(wlim + 2, 1) :
                        (pick < 93) ? $urandom_range(999, 10) :
                        (pick < 97) ? DIM_CAP : $urandom_range(99999, DIM_CAP + 1);
                digits = (n == 0) ? "" : $sformatf("%0d", n);
                if ($urandom_range(19) == 0)
                    digits = {"0", digits};
                push_text(digits);
                char_backlog = {char_backlog, tag};
                done += digits.len() + 1;
            end
        end
    endtask

    // Stimulus sequence.
    initial begin
        logic [10:0] w_set;
        logic [10:0] h_set;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single and zero counts, clipped runs, full-row ends,
        // blank rows, ignored bytes and a saturated count on a 4-wide grid.
        send_gap_pct   = 8;
        recv_stall_pct = 61;
        reg_write(REG_ROW_WIDTH, 11'd4);
        push_text("o0b5oo$3$x");
        char_backlog = {char_backlog, 8'h00};
        char_backlog = {char_backlog, 8'hFF};
        push_text("9999b2$");
        wait_drained();
        // Blank rows running past the height, then runs on dropped rows.
        reg_write(REG_ROW_COUNT, 11'd8);
        push_text("9$b2$");
        wait_drained();
        // Blank rows starting exactly at the height.
        reg_write(REG_ROW_COUNT, 11'd9);
        push_text("3$");

        // Random phases across grid sizes and back-pressure modes.
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            send_gap_pct   = (ph < 4) ? 8 : (ph < 8) ? 61 : 0;
            recv_stall_pct = (ph < 4) ? 61 : (ph < 8) ? 8 : 0;
            case (ph)
                0:       begin w_set = 11'd8;    h_set = 11'd1024; end
                1:       begin w_set = 11'd1;    h_set = 11'd1024; end
                2:       begin w_set = 11'd0;    h_set = 11'd1024; end
                3:       begin w_set = 11'd37;   h_set = 11'd1024; end
                4:       begin w_set = 11'd1024; h_set = 11'd1024; end
                5:       begin w_set = 11'd2047; h_set = 11'd1024; end
                6:       begin w_set = 11'd20;   h_set = 11'd1;    end
                7:       begin w_set = 11'd20;   h_set = 11'd0;    end
                8:       begin w_set = 11'd13;   h_set = 11'd2047; end
                9:       begin w_set = 11'd5;    h_set = 11'd1024; end
                default: begin
                    w_set = 11'($urandom_range(64, 1));
                    h_set = 11'($urandom_range(1024, 1));
                end
            endcase
            reg_write(REG_ROW_WIDTH, w_set);
            reg_write(REG_ROW_COUNT, h_set);
            gen_pattern(PHASE_ITEMS);
        end

        // Close the pattern, either filling the rest of the grid or with no
        // rows left, then show that later characters are ignored.
        wait_drained();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        reg_write(REG_ROW_WIDTH, 11'($urandom_range(40, 1)));
        if ($urandom_range(1) == 0)
            reg_write(REG_ROW_COUNT, 11'd0);
        else
            reg_write(REG_ROW_COUNT, GRID_LIMIT);
        push_text("3o!7b$!");
        char_backlog = {char_backlog, 8'hC3};
        wait_drained();

        if (mismatch_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

@@ life_rle_pattern_decoder.f @@
design/lrle_pkg.sv
design/life_rle_pattern_decoder.sv
tb/sv/testbench.sv
